>>> hdl/bhh_pkg.sv
// ----------------------------------------------------------------------------
// bhh_pkg
// Shared types and constants for the bilinear hyperplane hash signature unit.
// ----------------------------------------------------------------------------
package bhh_pkg;

	localparam int MAX_DIM    = 64;
	localparam int MAX_BITS   = 8;
	localparam int MAX_TABLES = 8;
	localparam int PROJ_DEPTH = MAX_TABLES * MAX_BITS * MAX_DIM;

	// fixed field widths
	localparam int LOAD_AW     = 12;
	localparam int VAL_W       = 16;
	localparam int SIG_W       = 32;
	localparam int TIDX_W      = 3;
	localparam int DIM_CFG_W   = 7;
	localparam int BITS_CFG_W  = 6;
	localparam int TABS_CFG_W  = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;

	// derived widths
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int BITS_W  = $clog2(MAX_BITS + 1);
	localparam int HB_W    = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
	localparam int TABS_W  = $clog2(MAX_TABLES + 1);
	localparam int TAB_W   = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
	localparam int MEM_AW  = (PROJ_DEPTH > 1) ? $clog2(PROJ_DEPTH) : 1;
	localparam int BASE_W  = (MEM_AW + 1 > LOAD_AW + 1) ? MEM_AW + 1 : LOAD_AW + 1;
	localparam int PROD_W  = 2 * VAL_W;
	localparam int ACC_W   = PROD_W + DIM_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DIM    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BITS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLES = 2'd2;

	localparam logic [DIM_CFG_W-1:0]  DIM_RST    = 7'd64;
	localparam logic [BITS_CFG_W-1:0] BITS_RST   = 6'd8;
	localparam logic [TABS_CFG_W-1:0] TABLES_RST = 4'd8;

	// item function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_DATA = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                    func;
		logic [LOAD_AW-1:0]      proj_addr;
		logic signed [VAL_W-1:0] proj_v_value;
		logic signed [VAL_W-1:0] proj_u_value;
		logic signed [VAL_W-1:0] element;
		logic                    is_query;
		logic                    last_element;
	} in_item_t;

	typedef struct packed {
		logic [TIDX_W-1:0] table_index;
		logic [SIG_W-1:0]  signature;
		logic              last_table;
	} out_item_t;

	// operand pair feeding the shared MAC
	typedef struct packed {
		logic                    vld;
		logic                    last;
		logic signed [VAL_W-1:0] x;
		logic signed [VAL_W-1:0] v;
		logic signed [VAL_W-1:0] u;
	} mac_op_t;

	typedef struct packed {
		logic done;
		logic hash_bit;
	} mac_res_t;

endpackage

>>> hdl/bhh_mac.sv
// ----------------------------------------------------------------------------
// bhh_mac
// Shared dual multiply-accumulate unit; forms one hash bit per dot-product pair.
// ----------------------------------------------------------------------------
module bhh_mac import bhh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mac_op_t  op,
	output mac_res_t res
);

	logic signed [VAL_W-1:0]  x, v, u;
	logic signed [PROD_W-1:0] prod_p_s2, prod_q_s2;
	logic                     vld_s2, last_s2;
	logic signed [ACC_W-1:0]  acc_p_q, acc_q_q;
	logic signed [ACC_W-1:0]  sum_p, sum_q;
	logic                     done_q, hash_bit_q;
	logic                     p_pos, p_neg, q_pos, q_neg;

	assign x = op.x;
	assign v = op.v;
	assign u = op.u;

	always_ff @(posedge clk) begin
		prod_p_s2 <= x * v;
		prod_q_s2 <= x * u;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s2  <= op.vld;
			last_s2 <= op.vld & op.last;
		end
	end

	assign sum_p = acc_p_q + ACC_W'(prod_p_s2);
	assign sum_q = acc_q_q + ACC_W'(prod_q_s2);

	assign p_pos = !sum_p[ACC_W-1] && (sum_p != '0);
	assign p_neg = sum_p[ACC_W-1];
	assign q_pos = !sum_q[ACC_W-1] && (sum_q != '0);
	assign q_neg = sum_q[ACC_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_p_q    <= '0;
			acc_q_q    <= '0;
			done_q     <= 1'b0;
			hash_bit_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (vld_s2) begin
				if (last_s2) begin
					// final term: decide the bit and start the next pair from zero
					acc_p_q    <= '0;
					acc_q_q    <= '0;
					done_q     <= 1'b1;
					hash_bit_q <= (p_pos && q_pos) || (p_neg && q_neg);
				end else begin
					acc_p_q <= sum_p;
					acc_q_q <= sum_q;
				end
			end
		end
	end

	assign res.done     = done_q;
	assign res.hash_bit = hash_bit_q;

endmodule

>>> hdl/bilinear_hyperplane_hash_signature.sv
// ----------------------------------------------------------------------------
// bilinear_hyperplane_hash_signature
// Bilinear hyperplane hash: per-table signatures from two projection memories.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/stall channel. func=0 items write one (v,u) coefficient pair
//           at proj_addr. func=1 items push one vector element;
//           the item with last_element set starts hashing.
//   out_* : valid/stall channel, one signature transfer per table, table 0 first,
//           last_table set on the final one.
//   cfg_* : single-cycle register writes, only while the block is idle (a user rule; unchecked).
// Timing: hashing feeds the MAC pair one element per cycle in the run state; it
//   pauses while each hash bit drains and while a stalled output holds a signature.
//   A vector occupies the block from its last element until its last signature is
//   loaded into the output register. in_stall stays high while hashing.
//   The limit is the single multiply-accumulate pair and the projection RAM port.
// Stall: the output register holds its signature; the sequencer waits before
//   loading the next one, so nothing is lost.
// Reset: element count cleared, registers back to dim 64, 8 bits, 8 tables.
//   Projection RAMs and the vector buffer are not cleared.
// ----------------------------------------------------------------------------
module bilinear_hyperplane_hash_signature import bhh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [DIM_CFG_W-1:0]  dim_cfg_q;
	logic [BITS_CFG_W-1:0] bits_cfg_q;
	logic [TABS_CFG_W-1:0] tables_cfg_q;
	logic [DIM_W-1:0]      d_eff;
	logic [BITS_W-1:0]     m_eff;
	logic [TABS_W-1:0]     l_eff;

	state_t                state_q, state_d;
	logic                  in_fire, load_we, elem_we;
	logic [DIM_W-1:0]      count_q, count_next, used_q;
	logic                  query_q;
	logic [IDX_W-1:0]      idx_q;
	logic [BASE_W-1:0]     base_q, scan_addr;
	logic [HB_W-1:0]       hb_q;
	logic [TAB_W-1:0]      t_q;
	logic [SIG_W-1:0]      sig_q;
	logic                  start, issue, issue_last, next_hasher, emit, last_tab;

	logic signed [VAL_W-1:0] proj_v_mem [PROJ_DEPTH];
	logic signed [VAL_W-1:0] proj_u_mem [PROJ_DEPTH];
	logic signed [VAL_W-1:0] vbuf_mem   [MAX_DIM];
	logic signed [VAL_W-1:0] v_rd_s1, u_rd_s1, x_rd_s1;
	logic                    vld_s1, last_s1, inr_s1;

	mac_op_t   mac_op;
	mac_res_t  mac_res;
	logic      out_valid_q;
	out_item_t out_data_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_cfg_q    <= DIM_RST;
			bits_cfg_q   <= BITS_RST;
			tables_cfg_q <= TABLES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIM:    dim_cfg_q    <= cfg_data;
				CFG_BITS:   bits_cfg_q   <= BITS_CFG_W'(cfg_data);
				CFG_TABLES: tables_cfg_q <= TABS_CFG_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// zero counts as one, large values saturate
	always_comb begin
		if (dim_cfg_q == '0)
			d_eff = DIM_W'(1);
		else if (int'(dim_cfg_q) > MAX_DIM)
			d_eff = DIM_W'(MAX_DIM);
		else
			d_eff = DIM_W'(dim_cfg_q);

		if (bits_cfg_q == '0)
			m_eff = BITS_W'(1);
		else if (int'(bits_cfg_q) > MAX_BITS)
			m_eff = BITS_W'(MAX_BITS);
		else
			m_eff = BITS_W'(bits_cfg_q);

		if (tables_cfg_q == '0)
			l_eff = TABS_W'(1);
		else if (int'(tables_cfg_q) > MAX_TABLES)
			l_eff = TABS_W'(MAX_TABLES);
		else
			l_eff = TABS_W'(tables_cfg_q);
	end

	// ---------------- input side ----------------
	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign load_we  = in_fire && (in_data.func == FUNC_LOAD)
		&& (int'(in_data.proj_addr) < PROJ_DEPTH);
	assign elem_we  = in_fire && (in_data.func == FUNC_DATA)
		&& (count_q < DIM_W'(MAX_DIM));
	assign count_next = elem_we ? count_q + 1'b1 : count_q;

	assign scan_addr = base_q + BASE_W'(idx_q);

	always_ff @(posedge clk) begin
		if (load_we) begin
			proj_v_mem[MEM_AW'(in_data.proj_addr)] <= in_data.proj_v_value;
			proj_u_mem[MEM_AW'(in_data.proj_addr)] <= in_data.proj_u_value;
		end
		v_rd_s1 <= proj_v_mem[scan_addr[MEM_AW-1:0]];
		u_rd_s1 <= proj_u_mem[scan_addr[MEM_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (elem_we)
			vbuf_mem[count_q[IDX_W-1:0]] <= in_data.element;
		x_rd_s1 <= vbuf_mem[idx_q];
	end

	// ---------------- sequencer ----------------
	assign last_tab = (TABS_W'(t_q) + 1'b1 == l_eff);

	always_comb begin
		state_d     = state_q;
		start       = 1'b0;
		issue       = 1'b0;
		issue_last  = 1'b0;
		next_hasher = 1'b0;
		emit        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && (in_data.func == FUNC_DATA) && in_data.last_element) begin
					start   = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue      = 1'b1;
				issue_last = (DIM_W'(idx_q) + 1'b1 == used_q);
				if (issue_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (mac_res.done) begin
					if (BITS_W'(hb_q) + 1'b1 == m_eff) begin
						state_d = ST_EMIT;
					end else begin
						next_hasher = 1'b1;
						state_d     = ST_RUN;
					end
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit    = 1'b1;
					state_d = last_tab ? ST_IDLE : ST_RUN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			used_q  <= '0;
			query_q <= 1'b0;
			idx_q   <= '0;
			base_q  <= '0;
			hb_q    <= '0;
			t_q     <= '0;
			sig_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			inr_s1  <= 1'b0;
		end else begin
			vld_s1  <= issue;
			last_s1 <= issue_last;
			inr_s1  <= (scan_addr < BASE_W'(PROJ_DEPTH));

			if (start)
				count_q <= '0;
			else if (elem_we)
				count_q <= count_next;

			if (start) begin
				used_q  <= (count_next < d_eff) ? count_next : d_eff;
				query_q <= in_data.is_query;
				idx_q   <= '0;
				base_q  <= '0;
				hb_q    <= '0;
				t_q     <= '0;
				sig_q   <= '0;
			end else begin
				if (issue) begin
					if (issue_last) begin
						idx_q  <= '0;
						base_q <= base_q + BASE_W'(d_eff);
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				if (next_hasher)
					hb_q <= hb_q + 1'b1;
				if (mac_res.done)
					sig_q <= {sig_q[SIG_W-2:0], mac_res.hash_bit ^ query_q};
				if (emit) begin
					sig_q <= '0;
					hb_q  <= '0;
					if (!last_tab)
						t_q <= t_q + 1'b1;
				end
			end
		end
	end

	// out-of-range entries contribute nothing
	assign mac_op.vld  = vld_s1;
	assign mac_op.last = last_s1;
	assign mac_op.x    = inr_s1 ? x_rd_s1 : '0;
	assign mac_op.v    = v_rd_s1;
	assign mac_op.u    = u_rd_s1;

	bhh_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.res    (mac_res)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q.table_index <= TIDX_W'(t_q);
			out_data_q.signature   <= sig_q;
			out_data_q.last_table  <= last_tab;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ---------------- assertions ----------------
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DIM_W'(MAX_DIM))
		else $error("element count beyond buffer depth");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (scan_addr < BASE_W'(PROJ_DEPTH)))
		else $error("projection scan address out of range");

	a_idx_used: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (DIM_W'(idx_q) < used_q))
		else $error("element index past vector length");

	a_done_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_res.done |-> (state_q == ST_DRAIN))
		else $error("hash bit finished outside drain");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("output loaded outside emit");

endmodule

>>> tb/sv/tb_bilinear_hyperplane_hash_signature.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_hyperplane_hash_signature
// Self-checking bench: fills both projection memories, then streams directed
// and random vectors under several register settings. A behavioral model
// predicts every table signature, and each output transfer is checked in order.
// ----------------------------------------------------------------------------
module tb_bilinear_hyperplane_hash_signature;
	import bhh_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int RANDOM_ITEMS   = 220;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_MAX, FILL_MIN} fill_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// model state
	logic signed [VAL_W-1:0] v_mem [PROJ_DEPTH];
	logic signed [VAL_W-1:0] u_mem [PROJ_DEPTH];
	logic signed [VAL_W-1:0] vec_buf [MAX_DIM];
	int                      elem_cnt = 0;
	logic [DIM_CFG_W-1:0]    dim_reg  = DIM_RST;
	logic [BITS_CFG_W-1:0]   bits_reg = BITS_RST;
	logic [TABS_CFG_W-1:0]   tabs_reg = TABLES_RST;

	out_item_t pending_sigs [$];

	bit steady = 1'b0;
	int errors = 0;
	int n_items = 0;
	int n_loads = 0;
	int n_vectors = 0;
	int n_checked = 0;
	int n_settings = 0;
	int quiet_cycles = 0;

	bilinear_hyperplane_hash_signature uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int clamp_reg(input int v, input int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// extremes and zero show up often enough to hit the sign corner cases
	function automatic logic [VAL_W-1:0] pick_fixed();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return VAL_W'($urandom_range(16'hffff));
		endcase
	endfunction

	task automatic predict_signatures(input in_item_t it);
		int d, m, l, used, base;
		longint p, q;
		logic [SIG_W-1:0] sig;
		logic hbit;
		out_item_t want;
		if (it.func == FUNC_LOAD) begin
			if (it.proj_addr < PROJ_DEPTH) begin
				v_mem[it.proj_addr] = it.proj_v_value;
				u_mem[it.proj_addr] = it.proj_u_value;
			end
			n_loads++;
		end else begin
			if (elem_cnt < MAX_DIM) begin
				vec_buf[elem_cnt] = it.element;
				elem_cnt++;
			end
			if (it.last_element) begin
				d = clamp_reg(int'(dim_reg), MAX_DIM);
				m = clamp_reg(int'(bits_reg), MAX_BITS);
				l = clamp_reg(int'(tabs_reg), MAX_TABLES);
				used = (elem_cnt < d) ? elem_cnt : d;
				for (int t = 0; t < l; t++) begin
					sig = '0;
					for (int b = 0; b < m; b++) begin
						p = 0;
						q = 0;
						base = (t * m + b) * d;
						for (int i = 0; i < used; i++) begin
							if (base + i < PROJ_DEPTH) begin
								p += longint'(vec_buf[i]) * longint'(v_mem[base + i]);
								q += longint'(vec_buf[i]) * longint'(u_mem[base + i]);
							end
						end
						hbit = (p > 0 && q > 0) || (p < 0 && q < 0);
						sig = {sig[SIG_W-2:0], hbit ^ it.is_query};
					end
					want.table_index = t[TIDX_W-1:0];
					want.signature   = sig;
					want.last_table  = (t == l - 1);
					pending_sigs.push_back(want);
				end
				elem_cnt = 0;
			end
		end
	endtask

	// valid stays up across back-to-back transfers; gaps only at falling edges
	task automatic send_item(input in_item_t it);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_signatures(it);
		n_items++;
	endtask

	task automatic send_load(input int addr, input logic [VAL_W-1:0] v, input logic [VAL_W-1:0] u);
		in_item_t it;
		it.func         = FUNC_LOAD;
		it.proj_addr    = LOAD_AW'(addr);
		it.proj_v_value = v;
		it.proj_u_value = u;
		it.element      = VAL_W'($urandom_range(16'hffff));
		it.is_query     = 1'($urandom_range(1));
		it.last_element = 1'($urandom_range(1));
		send_item(it);
	endtask

	task automatic send_vector(input int len, input fill_t fill, input bit query, input bit noisy);
		in_item_t it;
		for (int k = 0; k < len; k++) begin
			if (noisy && $urandom_range(9) == 0)
				send_load($urandom_range(PROJ_DEPTH - 1), pick_fixed(), pick_fixed());
			it.func         = FUNC_DATA;
			it.proj_addr    = LOAD_AW'($urandom_range(4095));
			it.proj_v_value = VAL_W'($urandom_range(16'hffff));
			it.proj_u_value = VAL_W'($urandom_range(16'hffff));
			case (fill)
				FILL_ZERO: it.element = 16'h0000;
				FILL_MAX:  it.element = 16'h7fff;
				FILL_MIN:  it.element = 16'h8000;
				default:   it.element = pick_fixed();
			endcase
			it.last_element = (k == len - 1);
			// only the flag on the closing element matters
			it.is_query     = (k == len - 1) ? query : 1'($urandom_range(1));
			send_item(it);
		end
		n_vectors++;
	endtask

	task automatic drain_and_settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_sigs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DIM:    dim_reg  = val;
			CFG_BITS:   bits_reg = val[BITS_CFG_W-1:0];
			CFG_TABLES: tabs_reg = val[TABS_CFG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_setting(input int dv, input int mv, input int lv);
		write_reg(CFG_DIM, CFG_DATA_W'(dv));
		write_reg(CFG_BITS, CFG_DATA_W'(mv));
		write_reg(CFG_TABLES, CFG_DATA_W'(lv));
		n_settings++;
	endtask

	// every projection entry gets written before any vector is hashed
	task automatic test_preload();
		for (int a = 0; a < PROJ_DEPTH; a++)
			send_load(a, pick_fixed(), pick_fixed());
	endtask

	task automatic test_reset_defaults();
		send_vector(3, FILL_RANDOM, 1'b0, 1'b0);
		send_vector(1, FILL_MAX, 1'b1, 1'b0);
		send_vector(2, FILL_MIN, 1'b0, 1'b0);
		// zero dot products: plain gives all-zero hash bits, query all-one hash bits
		send_vector(2, FILL_ZERO, 1'b0, 1'b0);
		send_vector(2, FILL_ZERO, 1'b1, 1'b0);
	endtask

	task automatic test_register_floor();
		drain_and_settle();
		write_setting(0, 0, 0);
		write_reg(CFG_UNUSED, 7'h7f);
		send_vector(1, FILL_MAX, 1'b0, 1'b0);
		send_vector(1, FILL_MIN, 1'b1, 1'b0);
		send_vector(3, FILL_RANDOM, 1'b0, 1'b0);
		send_vector(4, FILL_RANDOM, 1'b1, 1'b0);
	endtask

	task automatic test_full_size();
		drain_and_settle();
		write_setting(7'h7f, 7'h3f, 7'h0f);
		send_vector(MAX_DIM + 3, FILL_RANDOM, 1'b0, 1'b0);
		send_vector(MAX_DIM, FILL_RANDOM, 1'b1, 1'b0);
		// short vector right after a full one: stale buffer must not leak in
		send_vector(2, FILL_RANDOM, 1'b0, 1'b0);
	endtask

	task automatic test_random_traffic();
		int start, phase, dv, mv, lv, deff, len, r;
		start = n_items;
		phase = 0;
		while (n_items - start < RANDOM_ITEMS) begin
			drain_and_settle();
			if ($urandom_range(5) == 0) begin
				dv = $urandom_range(127);
				mv = $urandom_range(127);
				lv = $urandom_range(127);
			end else begin
				dv = $urandom_range(1, 8);
				mv = $urandom_range(1, 8);
				lv = $urandom_range(1, 4);
			end
			write_setting(dv, mv, lv);
			deff = clamp_reg(int'(dim_reg), MAX_DIM);
			steady = (phase == 3);
			repeat ($urandom_range(2, 5)) begin
				if (deff > 16) begin
					len = $urandom_range(1, 6);
				end else begin
					r = $urandom_range(9);
					if (r < 6)
						len = deff;
					else if (r < 8)
						len = $urandom_range(1, deff);
					else
						len = deff + $urandom_range(1, 3);
				end
				send_vector(len, FILL_RANDOM, 1'($urandom_range(1)), 1'b1);
			end
			steady = 1'b0;
			phase++;
		end
	endtask

	always @(negedge clk)
		out_stall <= !steady && ($urandom_range(99) < 8);

	always @(posedge clk) begin
		out_item_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = out_data;
			if (pending_sigs.size() == 0) begin
				$display("%0t: unexpected signature transfer: table %0d sig %h last %b",
					$time, got.table_index, got.signature, got.last_table);
				errors++;
			end else begin
				want = pending_sigs.pop_front();
				n_checked++;
				if (got.table_index !== want.table_index) begin
					$display("%0t: table_index mismatch: expected %0d, got %0d",
						$time, want.table_index, got.table_index);
					errors++;
				end
				if (got.signature !== want.signature) begin
					$display("%0t: signature mismatch (table %0d): expected %h, got %h",
						$time, want.table_index, want.signature, got.signature);
					errors++;
				end
				if (got.last_table !== want.last_table) begin
					$display("%0t: last_table mismatch (table %0d): expected %b, got %b",
						$time, want.table_index, want.last_table, got.last_table);
					errors++;
				end
			end
		end
	end

	// hashing is silent for long stretches; only a true hang trips this
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d signatures outstanding",
				$time, quiet_cycles, pending_sigs.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_preload();
		test_reset_defaults();
		test_register_floor();
		test_full_size();
		test_random_traffic();
		drain_and_settle();
		$display("Run covered %0d input items: %0d projection loads, %0d vectors, %0d settings.",
			n_items, n_loads, n_vectors, n_settings);
		$display("Signatures checked: %0d, mismatches: %0d.", n_checked, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
hdl/bhh_pkg.sv
hdl/bhh_mac.sv
hdl/bilinear_hyperplane_hash_signature.sv
tb/sv/tb_bilinear_hyperplane_hash_signature.sv
